[rtl/miller_rabin_round_defines.svh]
// ----------------------------------------------------------------------------
// miller_rabin_round assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_ROUND_DEFINES_SVH
`define MILLER_RABIN_ROUND_DEFINES_SVH

// same-cycle implication
`define MRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mrr_pkg.sv]
// ----------------------------------------------------------------------------
// mrr_pkg
// Types and constants shared by the Miller-Rabin round controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrr_pkg;

  localparam int WIDTH = 64;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_STRIP,
    S_RED_GO,
    S_RED_WAIT,
    S_POW,
    S_MULR_GO,
    S_MULR_WAIT,
    S_NEXT,
    S_SQB_GO,
    S_SQB_WAIT,
    S_LOOP,
    S_SQV_GO,
    S_SQV_WAIT,
    S_FIN,
    S_DONE
  } mrr_state_t;

  // modular multiply operand/destination selection
  typedef enum logic [1:0] {
    MM_RED,   // 1 * w  -> b   (reduces witness)
    MM_MULR,  // res * b -> res
    MM_SQB,   // b * b  -> b
    MM_SQV    // res * res -> res, t doubles
  } mm_op_t;

  typedef struct packed {
    logic   load;
    logic   set_trivial;
    logic   shift_e;
    logic   t_load;
    logic   mm_start;
    logic   mm_commit;
    mm_op_t mm_op;
    logic   set_final;
  } mrr_cmd_t;

  typedef struct packed {
    logic trivial;
    logic e_lsb;
    logic e_zero;
    logic e_hi_zero;
    logic mm_done;
    logic t_eq_nm1;
    logic v_is_one;
    logic v_is_nm1;
  } mrr_stat_t;

endpackage

`default_nettype wire

[rtl/mrr_mulmod.sv]
// ----------------------------------------------------------------------------
// mrr_mulmod
// Add-and-double modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_round_defines.svh"

module mrr_mulmod import mrr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire word_t x,
  input  wire word_t y,
  input  wire word_t m,
  output logic       done,
  output word_t      result
);

  logic  busy_r, busy_nxt;
  word_t acc_r, acc_nxt;
  word_t dbl_r, dbl_nxt;
  word_t y_r, y_nxt;

  logic [WIDTH:0] acc_sum, dbl_sum, m_ext;

  // operands stay below m, so one conditional subtract suffices
  assign m_ext   = {1'b0, m};
  assign acc_sum = {1'b0, acc_r} + {1'b0, dbl_r};
  assign dbl_sum = {1'b0, dbl_r} + {1'b0, dbl_r};

  assign done   = busy_r && (y_r == '0);
  assign result = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    dbl_nxt  = dbl_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      dbl_nxt  = x;
      y_nxt    = y;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (y_r[0]) begin
        acc_nxt = (acc_sum >= m_ext) ? WIDTH'(acc_sum - m_ext) : acc_sum[WIDTH-1:0];
      end
      dbl_nxt = (dbl_sum >= m_ext) ? WIDTH'(dbl_sum - m_ext) : dbl_sum[WIDTH-1:0];
      y_nxt   = {1'b0, y_r[WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dbl_r <= dbl_nxt;
    y_r   <= y_nxt;
  end

  `MRR_ASSERT_IMP(a_no_restart, start, !busy_r, "mulmod restarted while busy")
  `MRR_ASSERT_NXT(a_done_once, done, !done, "mulmod done held more than one cycle")
  `MRR_ASSERT_NXT(a_start_busy, start, busy_r, "mulmod not busy after start")

endmodule

`default_nettype wire

[rtl/mrr_datapath.sv]
// ----------------------------------------------------------------------------
// mrr_datapath
// Operand registers, exponent and squaring counters, verdict and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mrr_datapath import mrr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mrr_cmd_t cmd,
  input  wire word_t    candidate,
  input  wire word_t    witness,
  output mrr_stat_t     stat,
  output logic          verdict
);

  word_t n_r, n_nxt;
  word_t w_r, w_nxt;
  word_t nm1_r, nm1_nxt;
  word_t e_r, e_nxt;
  word_t t_r, t_nxt;
  word_t b_r, b_nxt;
  word_t res_r, res_nxt;
  logic  verdict_r, verdict_nxt;

  word_t mm_x, mm_y, mm_result;
  logic  mm_done;
  logic  n_le1, n_is2;

  assign n_le1 = (n_r[WIDTH-1:1] == '0);
  assign n_is2 = (n_r == WIDTH'(2));

  always_comb begin
    unique case (cmd.mm_op)
      MM_RED:  begin mm_x = WIDTH'(1); mm_y = w_r;   end
      MM_MULR: begin mm_x = res_r;     mm_y = b_r;   end
      MM_SQB:  begin mm_x = b_r;       mm_y = b_r;   end
      MM_SQV:  begin mm_x = res_r;     mm_y = res_r; end
      default: begin mm_x = res_r;     mm_y = res_r; end
    endcase
  end

  mrr_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (n_r),
    .done   (mm_done),
    .result (mm_result)
  );

  always_comb begin
    n_nxt       = n_r;
    w_nxt       = w_r;
    nm1_nxt     = nm1_r;
    e_nxt       = e_r;
    t_nxt       = t_r;
    b_nxt       = b_r;
    res_nxt     = res_r;
    verdict_nxt = verdict_r;
    if (cmd.load) begin
      n_nxt   = candidate;
      w_nxt   = witness;
      nm1_nxt = candidate - WIDTH'(1);
      e_nxt   = candidate - WIDTH'(1);
      res_nxt = WIDTH'(1);
    end
    if (cmd.set_trivial) verdict_nxt = n_is2;
    if (cmd.shift_e)     e_nxt = {1'b0, e_r[WIDTH-1:1]};
    if (cmd.t_load)      t_nxt = e_r;
    if (cmd.mm_commit) begin
      unique case (cmd.mm_op)
        MM_RED:  b_nxt = mm_result;
        MM_MULR: res_nxt = mm_result;
        MM_SQB:  b_nxt = mm_result;
        MM_SQV: begin
          res_nxt = mm_result;
          t_nxt   = {t_r[WIDTH-2:0], 1'b0};
        end
        default: res_nxt = mm_result;
      endcase
    end
    if (cmd.set_final) verdict_nxt = (res_r == nm1_r) || t_r[0];
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    w_r       <= w_nxt;
    nm1_r     <= nm1_nxt;
    e_r       <= e_nxt;
    t_r       <= t_nxt;
    b_r       <= b_nxt;
    res_r     <= res_nxt;
    verdict_r <= verdict_nxt;
  end

  assign stat.trivial   = n_le1 || !n_r[0];
  assign stat.e_lsb     = e_r[0];
  assign stat.e_zero    = (e_r == '0);
  assign stat.e_hi_zero = (e_r[WIDTH-1:1] == '0);
  assign stat.mm_done   = mm_done;
  assign stat.t_eq_nm1  = (t_r == nm1_r);
  assign stat.v_is_one  = (res_r == WIDTH'(1));
  assign stat.v_is_nm1  = (res_r == nm1_r);

  assign verdict = verdict_r;

endmodule

`default_nettype wire

[rtl/mrr_ctrl.sv]
// ----------------------------------------------------------------------------
// mrr_ctrl
// Sequencer for trivial checks, exponent walk and the squaring loop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_round_defines.svh"

module mrr_ctrl import mrr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire mrr_stat_t stat,
  output mrr_cmd_t       cmd,
  output logic           busy,
  output logic           out_valid
);

  mrr_state_t state_r, state_nxt;
  logic       in_wait;
  logic       decide;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (start) state_nxt = S_CHECK;
      S_CHECK:     state_nxt = stat.trivial ? S_DONE : S_STRIP;
      S_STRIP:     if (stat.e_lsb) state_nxt = S_RED_GO;
      S_RED_GO:    state_nxt = S_RED_WAIT;
      S_RED_WAIT:  if (stat.mm_done) state_nxt = S_POW;
      S_POW: begin
        priority if (stat.e_zero) state_nxt = S_LOOP;
        else if (stat.e_lsb)      state_nxt = S_MULR_GO;
        else                      state_nxt = S_NEXT;
      end
      S_MULR_GO:   state_nxt = S_MULR_WAIT;
      S_MULR_WAIT: if (stat.mm_done) state_nxt = S_NEXT;
      S_NEXT:      state_nxt = stat.e_hi_zero ? S_LOOP : S_SQB_GO;
      S_SQB_GO:    state_nxt = S_SQB_WAIT;
      S_SQB_WAIT:  if (stat.mm_done) state_nxt = S_POW;
      S_LOOP: begin
        if (stat.t_eq_nm1 || stat.v_is_one || stat.v_is_nm1) state_nxt = S_FIN;
        else state_nxt = S_SQV_GO;
      end
      S_SQV_GO:    state_nxt = S_SQV_WAIT;
      S_SQV_WAIT:  if (stat.mm_done) state_nxt = S_LOOP;
      S_FIN:       state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mm_op = MM_RED;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE:      cmd.load = start;
      S_CHECK:     cmd.set_trivial = 1'b1;
      S_STRIP: begin
        cmd.t_load  = stat.e_lsb;
        cmd.shift_e = !stat.e_lsb;
      end
      S_RED_GO:    cmd.mm_start = 1'b1;
      S_RED_WAIT:  cmd.mm_commit = stat.mm_done;
      S_POW:       cmd.mm_op = MM_MULR;
      S_MULR_GO: begin
        cmd.mm_op    = MM_MULR;
        cmd.mm_start = 1'b1;
      end
      S_MULR_WAIT: begin
        cmd.mm_op     = MM_MULR;
        cmd.mm_commit = stat.mm_done;
      end
      S_NEXT:      cmd.shift_e = 1'b1;
      S_SQB_GO: begin
        cmd.mm_op    = MM_SQB;
        cmd.mm_start = 1'b1;
      end
      S_SQB_WAIT: begin
        cmd.mm_op     = MM_SQB;
        cmd.mm_commit = stat.mm_done;
      end
      S_LOOP:      cmd.mm_op = MM_SQV;
      S_SQV_GO: begin
        cmd.mm_op    = MM_SQV;
        cmd.mm_start = 1'b1;
      end
      S_SQV_WAIT: begin
        cmd.mm_op     = MM_SQV;
        cmd.mm_commit = stat.mm_done;
      end
      S_FIN:       cmd.set_final = 1'b1;
      S_DONE:      out_valid = 1'b1;
      default:     out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  assign in_wait = (state_r == S_RED_WAIT) || (state_r == S_MULR_WAIT) ||
                   (state_r == S_SQB_WAIT) || (state_r == S_SQV_WAIT);
  assign decide  = (state_r == S_FIN) || (state_r == S_CHECK);

  `MRR_ASSERT_IMP(a_done_in_wait, stat.mm_done, in_wait, "multiply done outside a wait state")
  `MRR_ASSERT_IMP(a_start_idle_unit, cmd.mm_start, !stat.mm_done, "multiply issued while unit finishing")
  `MRR_ASSERT_NXT(a_done_path, !decide, state_r != S_DONE, "verdict word without a decision")

endmodule

`default_nettype wire

[rtl/miller_rabin_round.sv]
// ----------------------------------------------------------------------------
// miller_rabin_round
// One Miller-Rabin round on a 64-bit candidate with a caller-chosen witness.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_candidate and in_witness and raise start while busy is low; the
//   word is taken at that clock edge and busy stays high until the verdict.
//   out_passes_round is valid for the single cycle out_valid is high; the
//   receiver cannot stall, so the result must be captured in that cycle.
// Sequencing:
//   Candidates 0, 1, 2 and even numbers go from the check state straight to
//   the done state, and busy falls after out_valid. Otherwise each modular
//   multiply takes an issue state, one multiplier bit per cycle and a done
//   strobe high for a single cycle. A round takes one reduction of the
//   witness, at most a multiply and a squaring per exponent bit of the odd
//   part d, and up to r squarings. One word at a time; start again once
//   busy falls.
// Reset:
//   Synchronous active-low rst_n returns the sequencer to idle and drops any
//   round in progress; no result is produced for it.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_round import mrr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire word_t in_candidate,
  input  wire word_t in_witness,
  output logic       out_valid,
  output logic       out_passes_round
);

  mrr_cmd_t  cmd;
  mrr_stat_t stat;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mrr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .candidate (in_candidate),
    .witness   (in_witness),
    .stat      (stat),
    .verdict   (out_passes_round)
  );

endmodule

`default_nettype wire
